// ===== src/sat_pkg.sv =====
// ----------------------------------------------------------------------------
// sat_pkg: shared types and codes for the strongest access point table
// Action and outcome codes, the scan wavefront and the write command that
// travel along the chain of table cells.
// ----------------------------------------------------------------------------
package sat_pkg;

  // Largest table the chain supports and the widths that cover it.
  localparam int unsigned MAX_ENTRIES       = 64;
  localparam int unsigned MAX_IDX_W         = 6;
  localparam int unsigned MAX_CNT_W         = 7;
  localparam int unsigned DEF_TABLE_ENTRIES = 20;

  localparam int unsigned MAC_W   = 48;
  localparam int unsigned RSSI_W  = 8;
  localparam int unsigned RIDX_W  = 5;
  localparam int unsigned COUNT_W = 5;

  // Action codes.
  localparam logic [1:0] ACT_CLEAR  = 2'd0;
  localparam logic [1:0] ACT_REPORT = 2'd1;
  localparam logic [1:0] ACT_READ   = 2'd2;

  // Outcome codes.
  localparam logic [2:0] OC_APPENDED  = 3'd0;
  localparam logic [2:0] OC_REPLACED  = 3'd1;
  localparam logic [2:0] OC_DUPLICATE = 3'd2;
  localparam logic [2:0] OC_TOO_WEAK  = 3'd3;
  localparam logic [2:0] OC_NONE      = 3'd4;

  // Search key held steady while the wavefront runs down the chain.
  typedef struct packed {
    logic [MAC_W-1:0]     mac;
    logic [RIDX_W-1:0]    read_idx;
    logic [MAX_CNT_W-1:0] count;
  } key_t;

  // Partial results handed from cell to cell.
  typedef struct packed {
    logic                     dup;
    logic                     weak_set;
    logic signed [RSSI_W-1:0] weak_rssi;
    logic [MAX_IDX_W-1:0]     weak_idx;
    logic [MAC_W-1:0]         rd_mac;
    logic signed [RSSI_W-1:0] rd_rssi;
  } wave_t;

  // Broadcast write into one cell.
  typedef struct packed {
    logic                     en;
    logic [MAX_IDX_W-1:0]     idx;
    logic [MAC_W-1:0]         mac;
    logic signed [RSSI_W-1:0] rssi;
  } wr_cmd_t;

endpackage

// ===== src/sat_cell.sv =====
// ----------------------------------------------------------------------------
// sat_cell: one slot of the access point table
// Holds one MAC and RSSI, folds them into the passing wavefront (duplicate
// match, weakest entry, read capture) and registers the wavefront onward.
// ----------------------------------------------------------------------------
module sat_cell
  import sat_pkg::*;
#(
  parameter int unsigned CELL_IDX = 0
) (
  input  logic    clk,
  input  key_t    key,
  input  wave_t   wave_in,
  input  wr_cmd_t wr,
  output wave_t   wave_out
);

  localparam logic [MAX_CNT_W-1:0] POS = MAX_CNT_W'(CELL_IDX);

  logic [MAC_W-1:0]         mac;
  logic signed [RSSI_W-1:0] rssi;
  wave_t                    wave_next;

  always_comb begin
    wave_next = wave_in;
    if ((POS < key.count) && (mac == key.mac)) begin
      wave_next.dup = 1'b1;
    end
    // strict compare keeps the lowest index on ties
    if (!wave_in.weak_set || (rssi < wave_in.weak_rssi)) begin
      wave_next.weak_set  = 1'b1;
      wave_next.weak_rssi = rssi;
      wave_next.weak_idx  = POS[MAX_IDX_W-1:0];
    end
    if (POS == MAX_CNT_W'(key.read_idx)) begin
      wave_next.rd_mac  = mac;
      wave_next.rd_rssi = rssi;
    end
  end

  always_ff @(posedge clk) begin
    wave_out <= wave_next;
    if (wr.en && (wr.idx == POS[MAX_IDX_W-1:0])) begin
      mac  <= wr.mac;
      rssi <= wr.rssi;
    end
  end

endmodule

// ===== src/strongest_ap_table_top.sv =====
// ----------------------------------------------------------------------------
// strongest_ap_table_top: table of the strongest distinct access points
// Chain of table cells with a small controller for clear, report and read.
// ----------------------------------------------------------------------------
// Each accepted item sends a wavefront that walks the chain of cells one
// slot per cycle, looking for a duplicate MAC, the weakest entry and the
// entry to read. Once the last cell has registered it, the result goes into
// the output register, waiting while a previous result is not yet taken on
// m_axis_tready; the chosen write lands in the closing cycle. One item is in
// flight at a time; s_axis_tready is high while the block is idle, even if
// the previous result has not yet been taken.
// Reads of slots at or above the entry count return zeros.
module strongest_ap_table_top
  import sat_pkg::*;
#(
  parameter int unsigned TABLE_ENTRIES = DEF_TABLE_ENTRIES
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [63:0] s_axis_tdata,   // ap_mac[47:0], ap_rssi[55:48], read_index[60:56]
  input  logic [1:0]  s_axis_tuser,   // action[1:0]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [63:0] m_axis_tdata,   // entry_count[4:0], read_valid[5], read_mac[53:6],
                                      // read_rssi[61:54]
  output logic [2:0]  m_axis_tuser    // outcome[2:0]
);

  localparam int unsigned CNT_W  = $clog2(TABLE_ENTRIES + 1);
  localparam int unsigned SCAN_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;

  localparam logic [1:0] S_IDLE   = 2'd0;
  localparam logic [1:0] S_SCAN   = 2'd1;
  localparam logic [1:0] S_DECIDE = 2'd2;

  logic [1:0]               state;
  logic [SCAN_W-1:0]        scan_cnt;
  logic [CNT_W-1:0]         count;
  logic [CNT_W-1:0]         count_next;

  logic [1:0]               act;
  logic [MAC_W-1:0]         mac;
  logic signed [RSSI_W-1:0] rssi;
  logic [RIDX_W-1:0]        ridx;

  key_t                     key;
  wr_cmd_t                  wr;
  wave_t                    stage [TABLE_ENTRIES+1];
  wave_t                    last;

  logic                     accept;
  logic                     proceed;
  logic [2:0]               oc;
  logic                     rd_valid;

  assign s_axis_tready = (state == S_IDLE);
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign proceed       = (state == S_DECIDE) && (!m_axis_tvalid || m_axis_tready);

  assign key.mac      = mac;
  assign key.read_idx = ridx;
  assign key.count    = MAX_CNT_W'(count);

  // the wavefront enters the chain empty
  assign stage[0] = '0;
  assign last     = stage[TABLE_ENTRIES];

  for (genvar i = 0; i < TABLE_ENTRIES; i++) begin : g_cell
    sat_cell #(
      .CELL_IDX (i)
    ) u_cell (
      .clk      (clk),
      .key      (key),
      .wave_in  (stage[i]),
      .wr       (wr),
      .wave_out (stage[i+1])
    );
  end

  always_comb begin
    oc         = OC_NONE;
    count_next = count;
    wr.en      = 1'b0;
    wr.idx     = '0;
    wr.mac     = mac;
    wr.rssi    = rssi;
    unique case (act)
      ACT_CLEAR: begin
        count_next = '0;
      end
      ACT_REPORT: begin
        if (last.dup) begin
          oc = OC_DUPLICATE;
        end else if (count < CNT_W'(TABLE_ENTRIES)) begin
          oc         = OC_APPENDED;
          wr.en      = proceed;
          wr.idx     = MAX_IDX_W'(count);
          count_next = count + 1'b1;
        end else if (rssi > last.weak_rssi) begin
          oc     = OC_REPLACED;
          wr.en  = proceed;
          wr.idx = last.weak_idx;
        end else begin
          oc = OC_TOO_WEAK;
        end
      end
      default: begin
        oc = OC_NONE;
      end
    endcase
    rd_valid = (act == ACT_READ) && (MAX_CNT_W'(ridx) < MAX_CNT_W'(count));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      scan_cnt      <= '0;
      count         <= '0;
      m_axis_tvalid <= 1'b0;
    end else begin
      if (proceed) begin
        m_axis_tvalid <= 1'b1;
      end else if (m_axis_tvalid && m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            state    <= S_SCAN;
            scan_cnt <= '0;
          end
        end
        S_SCAN: begin
          // advance until the last cell has registered the wavefront
          scan_cnt <= scan_cnt + 1'b1;
          if (scan_cnt == SCAN_W'(TABLE_ENTRIES - 1)) begin
            state <= S_DECIDE;
          end
        end
        S_DECIDE: begin
          if (proceed) begin
            count <= count_next;
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // item and result payload
  always_ff @(posedge clk) begin
    if (accept) begin
      act  <= s_axis_tuser;
      mac  <= s_axis_tdata[47:0];
      rssi <= s_axis_tdata[55:48];
      ridx <= s_axis_tdata[60:56];
    end
    if (proceed) begin
      m_axis_tuser        <= oc;
      m_axis_tdata[4:0]   <= COUNT_W'(count_next);
      m_axis_tdata[5]     <= rd_valid;
      m_axis_tdata[53:6]  <= rd_valid ? last.rd_mac : '0;
      m_axis_tdata[61:54] <= rd_valid ? last.rd_rssi : '0;
      m_axis_tdata[63:62] <= 2'b00;
    end
  end

endmodule
